[src/icr_pkg.sv]
// Package for the identity cache: item types, per-way entry layout, codes and defaults.
// Depends on nothing; every other file imports it.
package icr_pkg;

   localparam int SETS_DEF = 256;
   localparam int WAYS_DEF = 16;
   localparam int CSR_AW = 2;
   localparam int SLOT_W = 12;

   localparam logic [31:0] HASH_MULT = 32'd2654435761;
   localparam logic [62:0] TTL_RESET = 63'd3000000000;
   localparam logic [62:0] GAP_RESET = 63'd20000000;

   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_DELIVER = 2'd1;
   localparam logic [1:0] FUNC_FLUSH = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_TTL = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_GAP = 2'd1;

   typedef struct packed {
      logic [1:0] func;
      logic [31:0] pid;
      logic [63:0] flow_id;
      logic [62:0] now_time;
      logic daemon_attached;
      logic [7:0] trust_in;
      logic sig_valid_in;
      logic [63:0] hash_in0;
      logic [63:0] hash_in1;
      logic [63:0] hash_in2;
      logic [63:0] hash_in3;
   } req_type;

   typedef struct packed {
      logic hit;
      logic [7:0] trust_out;
      logic sig_valid_out;
      logic [63:0] hash_out0;
      logic [63:0] hash_out1;
      logic [63:0] hash_out2;
      logic [63:0] hash_out3;
      logic query_emit;
      logic [31:0] query_pid;
      logic [63:0] query_flow;
      logic [SLOT_W-1:0] slot_index;
   } rsp_type;

   typedef struct packed {
      logic used;
      logic fresh;
      logic [31:0] key;
      logic [62:0] rtime;
      logic [62:0] qtime;
      logic [7:0] trust;
      logic sig;
      logic [255:0] hash;
   } way_type;

endpackage

[src/icr_set_hash.sv]
// Three-stage multiplicative hash of a process id reduced modulo the set count.
// Depends on icr_pkg.
module icr_set_hash import icr_pkg::*; #(
   parameter int SETS = SETS_DEF
) (
   input logic clock,
   input logic [31:0] pid,
   output logic [$clog2(SETS)-1:0] set_idx
);
   localparam int SET_W = $clog2(SETS);
   localparam logic [63:0] RECIP64 = (64'd1 << 32) / SETS;
   localparam logic [31:0] RECIP = RECIP64[31:0];
   localparam logic [SET_W+1:0] SETS_R = (SET_W+2)'(SETS);

   logic [31:0] h_ff, h2_ff, qe_ff;
   logic [63:0] prod1, prod2;
   logic [44:0] qs;
   logic [44:0] r_full;
   logic [SET_W+1:0] r0, r1, r2;
   logic [SET_W-1:0] set_ff;

   assign prod1 = {32'd0, pid} * {32'd0, HASH_MULT};
   assign prod2 = {32'd0, h_ff} * {32'd0, RECIP};
   assign qs = {13'd0, qe_ff} * 45'(SETS);
   assign r_full = {13'd0, h2_ff} - qs;
   assign r0 = r_full[SET_W+1:0];
   assign r1 = (r0 >= SETS_R) ? r0 - SETS_R : r0;
   assign r2 = (r1 >= SETS_R) ? r1 - SETS_R : r1;

   always_ff @(posedge clock) begin
      h_ff <= prod1[31:0];
      h2_ff <= h_ff;
      qe_ff <= prod2[63:32];
      set_ff <= r2[SET_W-1:0];
   end

   assign set_idx = set_ff;
endmodule

[src/identity_cache_ttl_rate_limit_unit.sv]
// Top level of the identity cache with TTL and query rate limit.
// Depends on icr_pkg and icr_set_hash.
// An item is taken when start is high and busy is low; its result appears for one cycle on
// rsp_valid and cannot be held off. Lookups and delivers pass through the hash states H1, H2
// and H3, a memory read, a way select, a scan for the oldest entry when a full set must
// evict, and an evaluate state that writes the set back and registers the result. A zero pid
// lookup, flush and unused codes answer in the next cycle. After reset and after every flush a
// clearing pass writes every set of the memory with busy high.
module identity_cache_ttl_rate_limit_unit import icr_pkg::*; #(
   parameter int SETS = SETS_DEF,
   parameter int WAYS = WAYS_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   input req_type req_data,
   output logic busy,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input logic csr_we,
   input logic [CSR_AW-1:0] csr_addr,
   input logic [62:0] csr_wdata
);
   localparam int SET_W = $clog2(SETS);
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_H1 = 4'd1;
   localparam logic [3:0] ST_H2 = 4'd2;
   localparam logic [3:0] ST_H3 = 4'd3;
   localparam logic [3:0] ST_READ = 4'd4;
   localparam logic [3:0] ST_LOOK = 4'd5;
   localparam logic [3:0] ST_SCAN = 4'd6;
   localparam logic [3:0] ST_EVAL = 4'd7;
   localparam logic [3:0] ST_CLEAR = 4'd8;

   way_type [WAYS-1:0] mem [SETS];

   logic [3:0] state_ff, state_in;
   req_type req_ff, req_in;
   way_type [WAYS-1:0] row_ff;
   logic [WAY_W-1:0] sel_ff, sel_in, scan_ff, scan_in;
   logic found_ff, found_in;
   logic [SET_W-1:0] clr_ff, clr_in;
   logic [62:0] ttl_ff, gap_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [SET_W-1:0] set_idx;
   logic mem_re, mem_we;
   logic [SET_W-1:0] mem_waddr;
   way_type [WAYS-1:0] mem_wdata;

   logic match_any, free_any;
   logic [WAY_W-1:0] match_idx, free_idx;
   way_type cur, upd, new_way;
   logic [62:0] age_r, age_q;
   logic fresh_ok, q_due;
   logic [31:0] slot_full;

   icr_set_hash #(.SETS(SETS)) u_hash (
      .clock(clock),
      .pid(req_ff.pid),
      .set_idx(set_idx)
   );

   always_comb begin
      match_any = 1'b0;
      free_any = 1'b0;
      match_idx = '0;
      free_idx = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_ff[w].used && row_ff[w].key == req_ff.pid) begin
            match_any = 1'b1;
            match_idx = WAY_W'(w);
         end
         if (!row_ff[w].used) begin
            free_any = 1'b1;
            free_idx = WAY_W'(w);
         end
      end
   end

   always_comb begin
      new_way = '0;
      new_way.used = 1'b1;
      new_way.key = req_ff.pid;
      cur = found_ff ? row_ff[sel_ff] : new_way;
      age_r = req_ff.now_time - cur.rtime;
      age_q = req_ff.now_time - cur.qtime;
      fresh_ok = cur.fresh && ((req_ff.now_time < cur.rtime) || (age_r < ttl_ff));
      q_due = (req_ff.now_time > cur.qtime) && (age_q > gap_ff);
      slot_full = 32'(set_idx) * 32'(WAYS) + 32'(sel_ff);
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      sel_in = sel_ff;
      scan_in = scan_ff;
      found_in = found_ff;
      clr_in = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      mem_re = 1'b0;
      mem_we = 1'b0;
      mem_waddr = set_idx;
      mem_wdata = row_ff;
      upd = cur;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '0;
               case (req_data.func)
                  FUNC_LOOKUP: begin
                     if (req_data.pid == 32'd0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_H1;
                     end
                  end
                  FUNC_DELIVER: begin
                     state_in = ST_H1;
                  end
                  FUNC_FLUSH: begin
                     rsp_valid_in = 1'b1;
                     clr_in = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_H1: state_in = ST_H2;
         ST_H2: state_in = ST_H3;
         ST_H3: state_in = ST_READ;
         ST_READ: begin
            mem_re = 1'b1;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (match_any) begin
               sel_in = match_idx;
               found_in = 1'b1;
               state_in = ST_EVAL;
            end else if (free_any) begin
               sel_in = free_idx;
               found_in = 1'b0;
               state_in = ST_EVAL;
            end else begin
               sel_in = '0;
               found_in = 1'b0;
               scan_in = WAY_W'(1);
               state_in = (WAYS > 1) ? ST_SCAN : ST_EVAL;
            end
         end
         ST_SCAN: begin
            if (row_ff[scan_ff].rtime < row_ff[sel_ff].rtime) begin
               sel_in = scan_ff;
            end
            scan_in = scan_ff + WAY_W'(1);
            if (scan_ff == WAY_W'(WAYS - 1)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            rsp_in = '0;
            rsp_in.slot_index = slot_full[SLOT_W-1:0];
            if (req_ff.func == FUNC_LOOKUP) begin
               if (fresh_ok) begin
                  rsp_in.hit = 1'b1;
                  rsp_in.trust_out = cur.trust;
                  rsp_in.sig_valid_out = cur.sig;
                  rsp_in.hash_out0 = cur.hash[63:0];
                  rsp_in.hash_out1 = cur.hash[127:64];
                  rsp_in.hash_out2 = cur.hash[191:128];
                  rsp_in.hash_out3 = cur.hash[255:192];
               end else begin
                  upd.fresh = 1'b0;
                  if (q_due) begin
                     upd.qtime = req_ff.now_time;
                     if (req_ff.daemon_attached) begin
                        rsp_in.query_emit = 1'b1;
                        rsp_in.query_pid = req_ff.pid;
                        rsp_in.query_flow = req_ff.flow_id;
                     end
                  end
               end
            end else begin
               upd.trust = req_ff.trust_in;
               upd.sig = req_ff.sig_valid_in;
               upd.hash = {req_ff.hash_in3, req_ff.hash_in2, req_ff.hash_in1, req_ff.hash_in0};
               upd.rtime = req_ff.now_time;
               upd.fresh = 1'b1;
            end
            mem_wdata[sel_ff] = upd;
            mem_we = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         row_ff <= mem[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      sel_ff <= sel_in;
      scan_ff <= scan_in;
      found_ff <= found_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ttl_ff <= TTL_RESET;
         gap_ff <= GAP_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_TTL: ttl_ff <= csr_wdata;
               CSR_GAP: gap_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_hit_no_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> !rsp_data.query_emit)
      else $error("hit together with a query");
   a_query_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.query_emit |-> rsp_data.query_pid == 32'd0)
      else $error("query pid set without a query");
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) || $past(reset))
      else $error("busy rose without an item");
   a_eval_responds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |=> rsp_valid)
      else $error("write back without a result");
endmodule

[tb/sv/identity_cache_ttl_rate_limit_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for identity_cache_ttl_rate_limit_unit: directed table, then random items
// checked against an in-bench model of the set-associative cache. Depends on icr_pkg and the RTL.
module identity_cache_ttl_rate_limit_unit_test;
   import icr_pkg::*;

   localparam int NSLOTS = SETS_DEF * WAYS_DEF;
   localparam logic [62:0] MAX63 = {63{1'b1}};
   localparam int SETTLE = 60;

   typedef struct {
      req_type req;
      bit typed;
      rsp_type rsp;
   } table_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   req_type req_data = '0;
   logic busy;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [62:0] csr_wdata = '0;

   identity_cache_ttl_rate_limit_unit uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   // Cache model state.
   logic [62:0] ttl_limit, query_gap;
   way_type cache_ways[NSLOTS];
   rsp_type pending_rsps[$];
   int mismatches = 0;
   int hits_seen = 0, queries_seen = 0, rsps_seen = 0;

   function automatic int set_of(logic [31:0] pid);
      logic [31:0] h;
      h = pid * HASH_MULT;
      return int'(h % SETS_DEF);
   endfunction

   function automatic int claim_way(int set_no, logic [31:0] pid);
      int pick;
      pick = -1;
      for (int w = 0; w < WAYS_DEF; w++) begin
         if (pick < 0 && !cache_ways[set_no * WAYS_DEF + w].used) pick = set_no * WAYS_DEF + w;
      end
      if (pick < 0) begin
         pick = set_no * WAYS_DEF;
         for (int w = 1; w < WAYS_DEF; w++) begin
            if (cache_ways[set_no * WAYS_DEF + w].rtime < cache_ways[pick].rtime)
               pick = set_no * WAYS_DEF + w;
         end
      end
      cache_ways[pick] = '0;
      cache_ways[pick].used = 1'b1;
      cache_ways[pick].key = pid;
      return pick;
   endfunction

   function automatic rsp_type cache_access(req_type r);
      rsp_type o;
      int set_no, s;
      bit fresh;
      logic [62:0] stamp;
      o = '0;
      s = -1;
      if (r.func == FUNC_FLUSH) begin
         for (int i = 0; i < NSLOTS; i++) begin
            cache_ways[i].used = 1'b0;
            cache_ways[i].fresh = 1'b0;
         end
         return o;
      end
      if (r.func != FUNC_LOOKUP && r.func != FUNC_DELIVER) return o;
      if (r.func == FUNC_LOOKUP && r.pid == 0) return o;
      set_no = set_of(r.pid);
      for (int w = 0; w < WAYS_DEF; w++) begin
         if (s < 0 && cache_ways[set_no * WAYS_DEF + w].used &&
             cache_ways[set_no * WAYS_DEF + w].key == r.pid) s = set_no * WAYS_DEF + w;
      end
      if (r.func == FUNC_DELIVER) begin
         if (s < 0) s = claim_way(set_no, r.pid);
         cache_ways[s].trust = r.trust_in;
         cache_ways[s].sig = r.sig_valid_in;
         cache_ways[s].hash = {r.hash_in3, r.hash_in2, r.hash_in1, r.hash_in0};
         cache_ways[s].rtime = r.now_time;
         cache_ways[s].fresh = 1'b1;
         o.slot_index = s[SLOT_W-1:0];
         return o;
      end
      if (s >= 0) begin
         fresh = 1'b0;
         if (cache_ways[s].fresh) begin
            stamp = cache_ways[s].rtime;
            fresh = (r.now_time < stamp) || ((r.now_time - stamp) < ttl_limit);
         end
         if (fresh) begin
            o.hit = 1'b1;
            o.trust_out = cache_ways[s].trust;
            o.sig_valid_out = cache_ways[s].sig;
            {o.hash_out3, o.hash_out2, o.hash_out1, o.hash_out0} = cache_ways[s].hash;
            o.slot_index = s[SLOT_W-1:0];
            return o;
         end
         cache_ways[s].fresh = 1'b0;
      end else begin
         s = claim_way(set_no, r.pid);
      end
      stamp = cache_ways[s].qtime;
      if (r.now_time > stamp && (r.now_time - stamp) > query_gap) begin
         cache_ways[s].qtime = r.now_time;
         if (r.daemon_attached) begin
            o.query_emit = 1'b1;
            o.query_pid = r.pid;
            o.query_flow = r.flow_id;
         end
      end
      o.slot_index = s[SLOT_W-1:0];
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         rsps_seen++;
         if (rsp_data.hit) hits_seen++;
         if (rsp_data.query_emit) queries_seen++;
         if (pending_rsps.size() == 0) begin
            $error("result with no item outstanding: %p", rsp_data);
            mismatches++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $error("hit: expected %0h, got %0h", want.hit, rsp_data.hit); mismatches++;
            end
            if (rsp_data.trust_out !== want.trust_out) begin
               $error("trust_out: expected %0h, got %0h", want.trust_out, rsp_data.trust_out);
               mismatches++;
            end
            if (rsp_data.sig_valid_out !== want.sig_valid_out) begin
               $error("sig_valid_out: expected %0h, got %0h", want.sig_valid_out,
                      rsp_data.sig_valid_out);
               mismatches++;
            end
            if (rsp_data.hash_out0 !== want.hash_out0) begin
               $error("hash_out0: expected %0h, got %0h", want.hash_out0, rsp_data.hash_out0);
               mismatches++;
            end
            if (rsp_data.hash_out1 !== want.hash_out1) begin
               $error("hash_out1: expected %0h, got %0h", want.hash_out1, rsp_data.hash_out1);
               mismatches++;
            end
            if (rsp_data.hash_out2 !== want.hash_out2) begin
               $error("hash_out2: expected %0h, got %0h", want.hash_out2, rsp_data.hash_out2);
               mismatches++;
            end
            if (rsp_data.hash_out3 !== want.hash_out3) begin
               $error("hash_out3: expected %0h, got %0h", want.hash_out3, rsp_data.hash_out3);
               mismatches++;
            end
            if (rsp_data.query_emit !== want.query_emit) begin
               $error("query_emit: expected %0h, got %0h", want.query_emit, rsp_data.query_emit);
               mismatches++;
            end
            if (rsp_data.query_pid !== want.query_pid) begin
               $error("query_pid: expected %0h, got %0h", want.query_pid, rsp_data.query_pid);
               mismatches++;
            end
            if (rsp_data.query_flow !== want.query_flow) begin
               $error("query_flow: expected %0h, got %0h", want.query_flow, rsp_data.query_flow);
               mismatches++;
            end
            if (rsp_data.slot_index !== want.slot_index) begin
               $error("slot_index: expected %0h, got %0h", want.slot_index, rsp_data.slot_index);
               mismatches++;
            end
         end
      end
   end

   // Entered and left at a falling edge; start stays high for a following item.
   task automatic send_item(req_type r, bit typed, rsp_type typed_rsp);
      logic was_busy;
      rsp_type model_rsp;
      start <= 1'b1;
      req_data <= r;
      forever begin
         #1 was_busy = busy;
         @(posedge clock);
         if (!was_busy) break;
         @(negedge clock);
      end
      model_rsp = cache_access(r);
      pending_rsps.push_back(typed ? typed_rsp : model_rsp);
      @(negedge clock);
   endtask

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_AW-1:0] addr, logic [62:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_TTL) ttl_limit = value;
      else query_gap = value;
      @(negedge clock);
   endtask

   function automatic req_type make_req(logic [1:0] func, logic [31:0] pid, logic [63:0] flow,
                                        logic [62:0] now, logic daemon, logic [7:0] trust,
                                        logic sig, logic [63:0] hash_word);
      req_type r;
      r.func = func;
      r.pid = pid;
      r.flow_id = flow;
      r.now_time = now;
      r.daemon_attached = daemon;
      r.trust_in = trust;
      r.sig_valid_in = sig;
      r.hash_in0 = hash_word;
      r.hash_in1 = ~hash_word;
      r.hash_in2 = hash_word;
      r.hash_in3 = ~hash_word;
      return r;
   endfunction

   initial begin
      table_row rows[$];
      table_row row;
      logic [31:0] crowded_pids[$];
      logic [62:0] ttl_choice[6], gap_choice[6];
      logic [62:0] clock_now;
      req_type r;
      logic [1:0] func;
      logic [31:0] pid;
      int pick, items_per_phase;
      bit idling;

      ttl_limit = TTL_RESET;
      query_gap = GAP_RESET;
      for (int i = 0; i < NSLOTS; i++) cache_ways[i] = '0;
      for (logic [31:0] p = 1; crowded_pids.size() < 22; p++) begin
         if (set_of(p) == 5) crowded_pids.push_back(p);
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Pid 1 hashes to set 177, so its first way is slot 2832.
      row = '{make_req(FUNC_LOOKUP, 0, '1, 63'd100000000, 1, '1, 1, '1), 1, '0};
      rows.push_back(row);
      row.req = make_req(FUNC_LOOKUP, 1, 64'hA5A5_0000_FFFF_1234, 63'd100000000, 1, 0, 0, 0);
      row.rsp = '0;
      row.rsp.query_emit = 1'b1;
      row.rsp.query_pid = 32'd1;
      row.rsp.query_flow = 64'hA5A5_0000_FFFF_1234;
      row.rsp.slot_index = 12'd2832;
      rows.push_back(row);
      rows.push_back('{make_req(FUNC_LOOKUP, 1, '1, 63'd100000000, 1, 0, 0, 0), 0, '0});
      row.req = make_req(FUNC_DELIVER, 1, 0, 63'd100000000, 0, 8'hFF, 1, '1);
      row.rsp = '0;
      row.rsp.slot_index = 12'd2832;
      rows.push_back(row);
      row.req = make_req(FUNC_LOOKUP, 1, 0, 63'd100000001, 0, 0, 0, 0);
      row.rsp = '0;
      row.rsp.hit = 1'b1;
      row.rsp.trust_out = 8'hFF;
      row.rsp.sig_valid_out = 1'b1;
      row.rsp.hash_out0 = '1;
      row.rsp.hash_out2 = '1;
      row.rsp.slot_index = 12'd2832;
      rows.push_back(row);
      rows.push_back('{make_req(FUNC_LOOKUP, 1, '1, MAX63, 1, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(FUNC_LOOKUP, 1, '1, MAX63, 1, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(FUNC_DELIVER, 1, 0, MAX63, 0, 8'h5A, 0, 64'h0123_4567_89AB_CDEF),
                       0, '0});
      rows.push_back('{make_req(FUNC_LOOKUP, 1, 0, 63'd0, 1, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(FUNC_DELIVER, 0, '1, 63'd7, 1, 8'h80, 1, '0), 0, '0});
      rows.push_back('{make_req(FUNC_LOOKUP, 0, '1, 63'd8, 1, 0, 0, 0), 1, '0});
      rows.push_back('{make_req(2'd3, '1, '1, MAX63, 1, '1, 1, '1), 1, '0});
      rows.push_back('{make_req(FUNC_LOOKUP, '1, '1, 63'd50000000, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(FUNC_LOOKUP, '1, '1, 63'd90000000, 1, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(FUNC_DELIVER, '1, 0, 63'd0, 0, 8'h01, 1, 64'hFFFF_0000_FFFF_0000),
                       0, '0});
      rows.push_back('{make_req(FUNC_LOOKUP, '1, 0, 63'd3000000000, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(FUNC_LOOKUP, '1, 0, 63'd2999999999, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_req(FUNC_FLUSH, '1, '1, MAX63, 1, '1, 1, '1), 1, '0});
      rows.push_back('{make_req(FUNC_LOOKUP, 1, '1, 63'd200000000, 1, 0, 0, 0), 0, '0});
      foreach (rows[i]) send_item(rows[i].req, rows[i].typed, rows[i].rsp);
      drain_results();

      // Phases of lifetime and query gap, extremes among them.
      ttl_choice = '{TTL_RESET, 63'd0, MAX63, 63'd500, 63'd2000, 63'd300};
      gap_choice = '{GAP_RESET, 63'd0, MAX63, 63'd50, 63'd0, 63'd100};
      clock_now = 63'd1000;
      items_per_phase = 240;
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         write_csr(CSR_TTL, ttl_choice[phase]);
         write_csr(CSR_GAP, gap_choice[phase]);
         idling = 1'b0;
         for (int n = 0; n < items_per_phase; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 1) func = FUNC_FLUSH;
            else if (pick < 3) func = 2'd3;
            else if (pick < 40) func = FUNC_DELIVER;
            else func = FUNC_LOOKUP;
            pick = $urandom_range(0, 99);
            if (pick < 50) pid = crowded_pids[$urandom_range(0, crowded_pids.size() - 1)];
            else if (pick < 85) pid = $urandom_range(1, 30);
            else if (pick < 95) pid = 0;
            else pid = $urandom;
            clock_now += 63'($urandom_range(0, 200));
            r = make_req(func, pid, {$urandom, $urandom}, clock_now, $urandom_range(0, 3) != 0,
                         8'($urandom), 1'($urandom), {$urandom, $urandom});
            r.hash_in1 = {$urandom, $urandom};
            r.hash_in3 = {$urandom, $urandom};
            if ($urandom_range(0, 19) == 0) r.now_time = 63'({$urandom, $urandom});
            send_item(r, 1'b0, '0);
            if (phase < 5) begin
               if ($urandom_range(0, 15) == 0) idling = !idling;
               if (idling && $urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 12));
            end
         end
      end
      drain_results();

      $display("Covered %0d results: %0d hits and %0d identity queries over six settings",
               rsps_seen, hits_seen, queries_seen);
      $display("of lifetime and query gap, with flushes, pid zero and full-set eviction.");
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
